### hdl/aging_neighbor_table_voter_core_assert.svh
// Assertion macros for the aging neighbor table voter core.
// Used by the checker module; no other dependencies.
`ifndef AGING_NEIGHBOR_TABLE_VOTER_CORE_ASSERT_SVH
`define AGING_NEIGHBOR_TABLE_VOTER_CORE_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define ANTV_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a stalled valid request keeps its payload.
`define ANTV_CHECK_HOLD(lbl, clk, rst_n, vld, stl, pay, msg) \
    `ANTV_CHECK(lbl, clk, rst_n, (vld && stl) |=> (vld && $stable(pay)), msg)

`endif

### hdl/antv_pkg.sv
// Package for the aging neighbor table voter core.
// Holds the request, response and table entry types, codes and helpers.
`default_nettype none

package antv_pkg;

    localparam int DEPTH_DEFAULT = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [15:0] MAX_AGE_RESET = 16'd200;
    localparam logic [7:0]  OPINION_RESET = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_OPINION = 2'd2;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OWN      = 3'd3;
    localparam logic [2:0] ST_STEP     = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] src_id;
        logic [7:0]  sender_opinion;
        logic [31:0] now_ms;
        logic [15:0] random_fraction;
    } t_in_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] opinion;
        logic [4:0] neighbor_count;
        logic       consensual;
        logic [4:0] disagree_count;
    } t_out_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  opinion;
        logic [31:0] seen_time;
    } t_entry;

    typedef struct packed {
        logic id_match;
        logic stale;
        logic differs;
    } t_eval;

    function automatic logic [4:0] sat5(input logic [7:0] v);
        logic [4:0] r;
        r = (v > 8'd31) ? 5'd31 : v[4:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/antv_entry_eval.sv
// Shared compare unit: evaluates one table entry against the current request.
// Depends on antv_pkg for the entry and result types.
`default_nettype none

module antv_entry_eval (
    input  antv_pkg::t_entry i_entry,
    input  logic [15:0]      i_src_id,
    input  logic [31:0]      i_now_ms,
    input  logic [15:0]      i_max_age,
    input  logic [7:0]       i_own_opinion,
    output antv_pkg::t_eval  o_eval
);

    logic [31:0] c_age;

    assign c_age           = i_now_ms - i_entry.seen_time;
    assign o_eval.stale    = c_age > {16'd0, i_max_age};
    assign o_eval.id_match = i_entry.id == i_src_id;
    assign o_eval.differs  = i_entry.opinion != i_own_opinion;

endmodule

`default_nettype wire

### hdl/aging_neighbor_table_voter_core.sv
// Top level of the aging neighbor table voter core.
// Depends on antv_pkg and antv_entry_eval.
//
// The core keeps a table of neighbors in a memory with one read and one write port
// and works on one request at a time, walking the table with one shared compare unit.
// A message from another node scans the entries in order until the sender's id
// matches and updates that entry; with no match it inserts the sender or reports the
// table full. A step purges stale entries from the top down, moving the last entry into
// each hole, then picks one remaining neighbor's opinion, counts the entries that differ
// from it and finishes. The registered memory read feeds the compare unit, so each entry
// passes a read state and a check state. While a request is in work the input is stalled;
// a finished response waits in the output register.
`default_nettype none

module aging_neighbor_table_voter_core #(
    parameter int TABLE_DEPTH = antv_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  antv_pkg::t_in_req                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output antv_pkg::t_out_rsp               o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [antv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [antv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 16 + CW;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_MREQ  = 14'b00000000000010,
        S_MCHK  = 14'b00000000000100,
        S_MMISS = 14'b00000000001000,
        S_PREQ  = 14'b00000000010000,
        S_PCHK  = 14'b00000000100000,
        S_PLAST = 14'b00000001000000,
        S_PMOVE = 14'b00000010000000,
        S_PICK  = 14'b00000100000000,
        S_PKRD  = 14'b00001000000000,
        S_POPIN = 14'b00010000000000,
        S_CREQ  = 14'b00100000000000,
        S_CCHK  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state               r_state, n_state;
    antv_pkg::t_in_req    r_req, n_req;
    logic [15:0]          r_own_id, n_own_id;
    logic [15:0]          r_max_age, n_max_age;
    logic [7:0]           r_own_opinion, n_own_opinion;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic [PW-1:0]        r_prod, n_prod;
    logic [CW-1:0]        r_dis, n_dis;
    logic [CW-1:0]        r_disagree, n_disagree;
    logic                 r_consensus, n_consensus;
    logic [2:0]           r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    antv_pkg::t_out_rsp   r_out, n_out;
    antv_pkg::t_entry     r_rdata;
    antv_pkg::t_entry     r_mem [TABLE_DEPTH];

    logic [AW-1:0]        c_raddr;
    logic                 c_we;
    logic [AW-1:0]        c_waddr;
    antv_pkg::t_entry     c_wdata;
    antv_pkg::t_eval      c_eval;
    logic [CW-1:0]        c_last;
    logic [CW-1:0]        c_dis_inc;
    logic                 c_accept;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign c_accept    = i_in_valid && !o_in_stall;
    assign c_last      = r_count - CW'(1);
    assign c_dis_inc   = r_dis + CW'(c_eval.differs);

    antv_entry_eval u_eval (
        .i_entry       (r_rdata),
        .i_src_id      (r_req.src_id),
        .i_now_ms      (r_req.now_ms),
        .i_max_age     (r_max_age),
        .i_own_opinion (r_own_opinion),
        .o_eval        (c_eval)
    );

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_own_id      = r_own_id;
        n_max_age     = r_max_age;
        n_own_opinion = r_own_opinion;
        n_count       = r_count;
        n_idx         = r_idx;
        n_prod        = r_prod;
        n_dis         = r_dis;
        n_disagree    = r_disagree;
        n_consensus   = r_consensus;
        n_status      = r_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        c_raddr       = r_idx;
        c_we          = 1'b0;
        c_waddr       = r_idx;
        c_wdata       = {r_req.src_id, r_req.sender_opinion, r_req.now_ms};

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                antv_pkg::CFG_OWN_ID:       n_own_id = i_cfg_data;
                antv_pkg::CFG_MAX_AGE:      n_max_age = i_cfg_data;
                antv_pkg::CFG_INIT_OPINION: n_own_opinion = i_cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_req = i_in;
                    if (i_in.opcode == antv_pkg::OP_MESSAGE) begin
                        if (i_in.src_id == r_own_id) begin
                            n_status = antv_pkg::ST_OWN;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_MMISS;
                        end else begin
                            n_idx   = '0;
                            n_state = S_MREQ;
                        end
                    end else if (r_count == '0) begin
                        n_state = S_PICK;
                    end else begin
                        n_idx   = c_last[AW-1:0];
                        n_state = S_PREQ;
                    end
                end
            end
            S_MREQ: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (c_eval.id_match) begin
                    c_we     = 1'b1;
                    n_status = antv_pkg::ST_UPDATED;
                    n_state  = S_DONE;
                end else if (CW'(r_idx) == c_last) begin
                    n_state = S_MMISS;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_MREQ;
                end
            end
            S_MMISS: begin
                if (r_count == CW'(TABLE_DEPTH)) begin
                    n_status = antv_pkg::ST_FULL;
                end else begin
                    c_we     = 1'b1;
                    c_waddr  = r_count[AW-1:0];
                    n_count  = r_count + CW'(1);
                    n_status = antv_pkg::ST_INSERTED;
                end
                n_state = S_DONE;
            end
            S_PREQ: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (c_eval.stale) begin
                    n_state = S_PLAST;
                end else if (r_idx == '0) begin
                    n_state = S_PICK;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PREQ;
                end
            end
            S_PLAST: begin
                c_raddr = c_last[AW-1:0];
                n_state = S_PMOVE;
            end
            S_PMOVE: begin
                c_we    = 1'b1;
                c_wdata = r_rdata;
                n_count = c_last;
                if (r_idx == '0) begin
                    n_state = S_PICK;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PREQ;
                end
            end
            S_PICK: begin
                if (r_count == '0) begin
                    n_consensus = 1'b1;
                    n_disagree  = '0;
                    n_status    = antv_pkg::ST_STEP;
                    n_state     = S_DONE;
                end else begin
                    n_prod  = PW'(r_req.random_fraction) * PW'(r_count);
                    n_state = S_PKRD;
                end
            end
            S_PKRD: begin
                c_raddr = r_prod[16 +: AW];
                n_state = S_POPIN;
            end
            S_POPIN: begin
                n_own_opinion = r_rdata.opinion;
                n_idx         = '0;
                n_dis         = '0;
                n_state       = S_CREQ;
            end
            S_CREQ: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                n_dis = c_dis_inc;
                if (CW'(r_idx) == c_last) begin
                    n_disagree  = c_dis_inc;
                    n_consensus = c_dis_inc == '0;
                    n_status    = antv_pkg::ST_STEP;
                    n_state     = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_CREQ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.opinion        = r_own_opinion;
                    n_out.neighbor_count = antv_pkg::sat5(8'(r_count));
                    n_out.consensual     = r_consensus;
                    n_out.disagree_count = antv_pkg::sat5(8'(r_disagree));
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_own_id      <= '0;
            r_max_age     <= antv_pkg::MAX_AGE_RESET;
            r_own_opinion <= antv_pkg::OPINION_RESET;
            r_count       <= '0;
            r_disagree    <= '0;
            r_consensus   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_own_id      <= n_own_id;
            r_max_age     <= n_max_age;
            r_own_opinion <= n_own_opinion;
            r_count       <= n_count;
            r_disagree    <= n_disagree;
            r_consensus   <= n_consensus;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_dis    <= n_dis;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= c_wdata;
        end
        r_rdata <= r_mem[c_raddr];
    end

endmodule

`default_nettype wire

### hdl/antv_checker.sv
// Port-level checker for the aging neighbor table voter core, with its bind.
// Depends on antv_pkg and the assertion macro header.
`default_nettype none

`include "aging_neighbor_table_voter_core_assert.svh"

module antv_checker #(
    parameter int TABLE_DEPTH = antv_pkg::DEPTH_DEFAULT
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input antv_pkg::t_out_rsp               o_out
);

    localparam logic [4:0] MAX_SHOWN = 5'((TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH);

    `ANTV_CHECK_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_stall, o_out,
        "Stalled response changed.")

    `ANTV_CHECK(a_one_at_a_time, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> o_in_stall,
        "Input accepted while a request was in work.")

    `ANTV_CHECK(a_count_bound, i_clk, i_rst_n,
        o_out_valid |-> (o_out.neighbor_count <= MAX_SHOWN
            && o_out.disagree_count <= MAX_SHOWN),
        "Count beyond table depth.")

    `ANTV_CHECK(a_step_consensus, i_clk, i_rst_n,
        (o_out_valid && o_out.status == antv_pkg::ST_STEP) |->
            (o_out.consensual == (o_out.disagree_count == 5'd0)
            && o_out.disagree_count <= o_out.neighbor_count),
        "Step result inconsistent with consensus.")

endmodule

bind aging_neighbor_table_voter_core antv_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_antv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aging_neighbor_table_voter_core: predicts each reply
// from its own copy of the neighbor table and compares it field by field.
// Depends on antv_pkg and the core RTL only.

class neighbor_vote_scoreboard;
    logic [15:0]        nb_id      [antv_pkg::DEPTH_DEFAULT];
    logic [7:0]         nb_opinion [antv_pkg::DEPTH_DEFAULT];
    logic [31:0]        nb_seen    [antv_pkg::DEPTH_DEFAULT];
    int unsigned        nb_count;
    logic [15:0]        own_id;
    logic [15:0]        max_age;
    logic [7:0]         own_opinion;
    logic               consensus;
    int unsigned        disagree;
    antv_pkg::t_out_rsp node_reports[$];
    int unsigned        errors;
    int unsigned        status_tally[5];
    int unsigned        consensus_steps;

    function new();
        own_id          = '0;
        max_age         = antv_pkg::MAX_AGE_RESET;
        own_opinion     = antv_pkg::OPINION_RESET;
        consensus       = 1'b0;
        disagree        = 0;
        nb_count        = 0;
        errors          = 0;
        consensus_steps = 0;
        foreach (status_tally[k]) status_tally[k] = 0;
    endfunction

    function int unsigned pending();
        return node_reports.size();
    endfunction

    function void apply_register(input logic [antv_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [antv_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            antv_pkg::CFG_OWN_ID:       own_id = data;
            antv_pkg::CFG_MAX_AGE:      max_age = data;
            antv_pkg::CFG_INIT_OPINION: own_opinion = data[7:0];
            default: ;
        endcase
    endfunction

    function void apply_request(input antv_pkg::t_in_req r);
        antv_pkg::t_out_rsp e;
        int unsigned        k;
        int unsigned        slot;
        int unsigned        last;
        int unsigned        pick;
        int unsigned        frac;
        logic [31:0]        age;
        if (r.opcode == antv_pkg::OP_MESSAGE) begin
            slot = nb_count;
            for (k = 0; k < nb_count; k++) begin
                if (slot == nb_count && nb_id[k] == r.src_id) slot = k;
            end
            if (r.src_id == own_id) begin
                e.status = antv_pkg::ST_OWN;
            end else if (slot == nb_count && nb_count >= antv_pkg::DEPTH_DEFAULT) begin
                e.status = antv_pkg::ST_FULL;
            end else begin
                e.status = (slot == nb_count) ? antv_pkg::ST_INSERTED : antv_pkg::ST_UPDATED;
                if (slot == nb_count) nb_count++;
                nb_id[slot]      = r.src_id;
                nb_opinion[slot] = r.sender_opinion;
                nb_seen[slot]    = r.now_ms;
            end
        end else begin
            // Purge from the top down, filling each hole with the last entry.
            for (k = nb_count; k > 0; k--) begin
                age = r.now_ms - nb_seen[k-1];
                if (age > {16'd0, max_age}) begin
                    last            = nb_count - 1;
                    nb_id[k-1]      = nb_id[last];
                    nb_opinion[k-1] = nb_opinion[last];
                    nb_seen[k-1]    = nb_seen[last];
                    nb_count--;
                end
            end
            if (nb_count != 0) begin
                frac = r.random_fraction;
                pick = (frac * nb_count) >> 16;
                if (pick >= nb_count) pick = nb_count - 1;
                own_opinion = nb_opinion[pick];
            end
            disagree = 0;
            for (k = 0; k < nb_count; k++) begin
                if (nb_opinion[k] != own_opinion) disagree++;
            end
            consensus = (disagree == 0);
            e.status  = antv_pkg::ST_STEP;
            if (consensus && nb_count != 0) consensus_steps++;
        end
        e.opinion        = own_opinion;
        e.neighbor_count = 5'(nb_count);
        e.consensual     = consensus;
        e.disagree_count = 5'(disagree);
        status_tally[e.status]++;
        node_reports.push_back(e);
    endfunction

    task report(input string what);
        errors++;
        if (errors <= 40) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_reply(input antv_pkg::t_out_rsp got);
        antv_pkg::t_out_rsp e;
        if (node_reports.size() == 0) begin
            report("reply arrived with no request outstanding");
        end else begin
            e = node_reports.pop_front();
            if (got.status !== e.status)
                report($sformatf("status got %0d expected %0d", got.status, e.status));
            if (got.opinion !== e.opinion)
                report($sformatf("opinion got %0d expected %0d", got.opinion, e.opinion));
            if (got.neighbor_count !== e.neighbor_count)
                report($sformatf("neighbor_count got %0d expected %0d",
                                 got.neighbor_count, e.neighbor_count));
            if (got.consensual !== e.consensual)
                report($sformatf("consensual got %0d expected %0d",
                                 got.consensual, e.consensual));
            if (got.disagree_count !== e.disagree_count)
                report($sformatf("disagree_count got %0d expected %0d",
                                 got.disagree_count, e.disagree_count));
        end
    endtask
endclass

module tb;

    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 265;
    localparam int POOL_N          = 28;
    localparam logic [antv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    antv_pkg::t_in_req                   i_in;
    logic                                o_out_valid;
    logic                                i_out_stall;
    antv_pkg::t_out_rsp                  o_out;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [antv_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [antv_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    neighbor_vote_scoreboard sb = new();

    int          idle_pct = 22;
    int          stall_pct = 22;
    int          quiet_cycles = 0;
    int          settings_used = 1;
    int          op_span;
    logic [31:0] clock_ms;
    logic [15:0] cur_own_id;
    logic [15:0] cur_max_age;
    logic [15:0] id_pool [POOL_N];

    aging_neighbor_table_voter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_reply(o_out);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic antv_pkg::t_in_req make_request(input logic op,
                                                       input logic [15:0] id,
                                                       input logic [7:0] opn,
                                                       input logic [31:0] now,
                                                       input logic [15:0] frac);
        antv_pkg::t_in_req r;
        r.opcode          = op;
        r.src_id          = id;
        r.sender_opinion  = opn;
        r.now_ms          = now;
        r.random_fraction = frac;
        return r;
    endfunction

    task automatic push_request(input antv_pkg::t_in_req r);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 60) : 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.apply_request(r);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [antv_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [antv_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_register(idx, data);
    endtask

    task automatic run_directed();
        logic m;
        logic s;
        m = antv_pkg::OP_MESSAGE;
        s = antv_pkg::OP_STEP;
        // Default registers: own id 0, age limit 200, opinion 0.
        push_request(make_request(s, 16'h0000, 8'h00, 32'h0000_0000, 16'hFFFF));
        push_request(make_request(m, 16'h0000, 8'hFF, 32'h0000_0000, 16'hFFFF));
        push_request(make_request(m, 16'hFFFF, 8'hFF, 32'h0000_0000, 16'h0000));
        push_request(make_request(m, 16'hFFFF, 8'h00, 32'h0000_0005, 16'h0000));
        push_request(make_request(m, 16'h0001, 8'h80, 32'h0000_000A, 16'h1234));
        push_request(make_request(m, 16'h8000, 8'h7F, 32'h0000_00C8, 16'h0000));
        push_request(make_request(s, 16'hFFFF, 8'hFF, 32'h0000_00C8, 16'hFFFF));
        push_request(make_request(s, 16'h0000, 8'h00, 32'h0000_00D2, 16'h0000));
        push_request(make_request(m, 16'h0001, 8'h00, 32'hFFFF_FFF0, 16'hFFFF));
        push_request(make_request(m, 16'h0002, 8'h00, 32'hFFFF_FFFF, 16'h8000));
        push_request(make_request(s, 16'h5A5A, 8'hA5, 32'h0000_0050, 16'h8000));
        push_request(make_request(s, 16'h0000, 8'h00, 32'h0000_0100, 16'h4000));
        push_request(make_request(s, 16'h0000, 8'h00, 32'h0000_0200, 16'h0000));
        push_request(make_request(m, 16'h0000, 8'h11, 32'h0000_0300, 16'h0000));
    endtask

    task automatic start_phase(input int phase);
        logic [15:0] own;
        logic [15:0] age;
        logic [15:0] init;
        int          k;
        own       = 16'($urandom);
        age       = 16'($urandom_range(20, 2000));
        init      = 16'($urandom);
        clock_ms  = $urandom;
        op_span   = 2;
        idle_pct  = 22;
        stall_pct = 22;
        case (phase)
            0: begin
                own     = 16'hFFFF;
                age     = 16'h0000;
                init    = 16'hFFFF;
                op_span = 1;
            end
            1: begin
                own      = 16'h0000;
                age      = 16'hFFFF;
                init     = 16'h0000;
                clock_ms = 32'hFFFF_0000;
            end
            2: begin
                age       = antv_pkg::MAX_AGE_RESET;
                idle_pct  = 0;
                stall_pct = 0;
                op_span   = 3;
            end
            3: begin
                age      = 16'($urandom);
                clock_ms = 32'hFFFF_FF00;
            end
            default: ;
        endcase
        for (k = 0; k < POOL_N; k++) id_pool[k] = 16'($urandom);
        if (phase == 5) id_pool[0] = own;
        settle();
        write_register(antv_pkg::CFG_OWN_ID, own);
        write_register(antv_pkg::CFG_MAX_AGE, age);
        if (phase % 2 == 0) write_register(CFG_SPARE, 16'($urandom));
        write_register(antv_pkg::CFG_INIT_OPINION, init);
        i_cfg_valid <= 1'b0;
        cur_own_id  = own;
        cur_max_age = age;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        antv_pkg::t_in_req r;
        int                k;
        int                roll;
        for (k = 0; k < n; k++) begin
            r.src_id          = id_pool[$urandom_range(0, POOL_N - 1)];
            r.sender_opinion  = 8'($urandom_range(0, op_span));
            r.random_fraction = 16'($urandom_range(0, 65535));
            roll              = $urandom_range(0, 99);
            r.opcode          = (roll < 70) ? antv_pkg::OP_MESSAGE : antv_pkg::OP_STEP;
            if (roll < 4) r.src_id = cur_own_id;
            else if (roll < 8) r.src_id = 16'($urandom);
            if ($urandom_range(0, 99) < 15) r.sender_opinion = 8'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 3) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, cur_max_age / 6 + 1);
            r.now_ms = (roll >= 97) ? 32'($urandom) : clock_ms;
            push_request(r);
        end
    endtask

    initial begin
        int phase;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (phase = 0; phase < PHASES; phase++) begin
            start_phase(phase);
            run_random(ITEMS_PER_PHASE);
        end
        settle();
        $display("Run covered %0d messages and %0d steps under %0d register settings.",
                 sb.status_tally[antv_pkg::ST_UPDATED] +
                 sb.status_tally[antv_pkg::ST_INSERTED] +
                 sb.status_tally[antv_pkg::ST_FULL] + sb.status_tally[antv_pkg::ST_OWN],
                 sb.status_tally[antv_pkg::ST_STEP], settings_used);
        $display("Refreshes %0d, inserts %0d, full drops %0d, own-id %0d, consensus %0d.",
                 sb.status_tally[antv_pkg::ST_UPDATED],
                 sb.status_tally[antv_pkg::ST_INSERTED],
                 sb.status_tally[antv_pkg::ST_FULL], sb.status_tally[antv_pkg::ST_OWN],
                 sb.consensus_steps);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/antv_pkg.sv
hdl/antv_entry_eval.sv
hdl/aging_neighbor_table_voter_core.sv
hdl/antv_checker.sv
dv/tb.sv
